### design/enveloped_sine_tone_generator_defines.svh
// Assertion macros used by the tone generator's top-level RTL file.
`ifndef ENVELOPED_SINE_TONE_GENERATOR_DEFINES_SVH
`define ENVELOPED_SINE_TONE_GENERATOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ESTG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ESTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/estg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the tone generator.
`default_nettype none

package estg_pkg;

  localparam int SINE_DEPTH  = 256;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);
  localparam int POS_W       = SINE_AW + 2;
  localparam int SINE_MAG_W  = 15;
  localparam int ENV_STEPS   = 16;
  localparam int AMP_W       = 13;
  localparam int ACC_W       = AMP_W + ENV_STEPS;
  localparam int PROD_W      = ACC_W + SINE_MAG_W;
  localparam int PROD_SHIFT  = 31;

  localparam int VOL_W       = 7;
  localparam int FREQ_W      = 13;
  localparam int DUR_W       = 14;
  localparam int SAMPLE_W    = 14;
  localparam int IDX_W       = 18;
  localparam int CFG_IDX_W   = 2;

  localparam int MS_PER_S    = 1000;
  localparam int FADE_DIV    = 50;

  localparam logic [IDX_W-1:0]      MAX_TOTAL   = '1;
  localparam logic [VOL_W-1:0]      VOL_MAX     = 7'd100;
  localparam logic [AMP_W-1:0]      AMP_PER_PCT = 13'd80;
  localparam logic [SINE_MAG_W-1:0] SINE_PEAK   = 15'h7fff;

  localparam logic [VOL_W-1:0]  VOL_RESET  = 7'd80;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 13'd1000;
  localparam logic [DUR_W-1:0]  DUR_RESET  = 14'd100;

  typedef logic [CFG_IDX_W-1:0] estg_cfg_idx_t;
  localparam estg_cfg_idx_t CFG_VOLUME   = 2'd0;
  localparam estg_cfg_idx_t CFG_FREQ     = 2'd1;
  localparam estg_cfg_idx_t CFG_DURATION = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_DONE
  } estg_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic pos_step;
    logic mul;
  } estg_dp_ctl_t;

  typedef logic [15:0] sine_rom_t [SINE_DEPTH];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  function automatic logic [15:0] sine_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
    x2 = (x * x) >> 30;
    h  = ONE_Q30;
    h  = ONE_Q30 - ((x2 * h) >> 30) / 110;
    h  = ONE_Q30 - ((x2 * h) >> 30) / 72;
    h  = ONE_Q30 - ((x2 * h) >> 30) / 42;
    h  = ONE_Q30 - ((x2 * h) >> 30) / 20;
    h  = ONE_Q30 - ((x2 * h) >> 30) / 6;
    s  = (x * h) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### design/estg_sample_dp.sv
// Bit-serial sample datapath: envelope divide-and-scale, phase position, sine lookup, product.
`default_nettype none

module estg_sample_dp #(
  parameter int FS_HZ = 16000
) (
  input  wire logic                                 clk,
  input  wire estg_pkg::estg_dp_ctl_t               ctl,
  input  wire logic [$clog2(FS_HZ/estg_pkg::FADE_DIV)-1:0] env_num,
  input  wire logic                                 env_full,
  input  wire logic [estg_pkg::AMP_W-1:0]           amp,
  input  wire logic [$clog2(FS_HZ)-1:0]             residue,
  output logic      [estg_pkg::AMP_W-1:0]           mag,
  output logic                                      neg
);

  localparam int PHASE_W = $clog2(FS_HZ);
  localparam int FADE    = FS_HZ / estg_pkg::FADE_DIV;
  localparam int N_W     = $clog2(FADE);
  localparam int ACC_W   = estg_pkg::ACC_W;
  localparam int POS_W   = estg_pkg::POS_W;
  localparam int AW      = estg_pkg::SINE_AW;
  localparam int PROD_W  = estg_pkg::PROD_W;

  localparam logic [N_W:0]     FADE_K = (N_W + 1)'(FADE);
  localparam logic [PHASE_W:0] SR_K   = (PHASE_W + 1)'(FS_HZ);

  logic [N_W-1:0]                     env_rem_r;
  logic [ACC_W-1:0]                   acc_r;
  logic [estg_pkg::AMP_W-1:0]         amp_r;
  logic [PHASE_W-1:0]                 pos_rem_r;
  logic [POS_W-1:0]                   pos_r;
  logic [15:0]                        tab_r;
  logic [PROD_W-1:0]                  prod_r;

  logic [N_W:0]                       env_dbl;
  logic [N_W:0]                       env_sub;
  logic                               env_bit;
  logic [ACC_W-1:0]                   acc_nxt;
  logic [PHASE_W:0]                   pos_dbl;
  logic [PHASE_W:0]                   pos_sub;
  logic                               pos_bit;
  logic                               quad_odd;
  logic [AW-1:0]                      k_idx;
  logic [AW-1:0]                      rom_addr;
  logic [estg_pkg::SINE_MAG_W-1:0]    sine_mag;

  always_comb begin
    env_dbl  = {env_rem_r, 1'b0};
    env_bit  = (env_dbl >= FADE_K);
    env_sub  = env_dbl - FADE_K;
    acc_nxt  = {acc_r[ACC_W-2:0], 1'b0} + (env_bit ? ACC_W'(amp_r) : ACC_W'(0));
    pos_dbl  = {pos_rem_r, 1'b0};
    pos_bit  = (pos_dbl >= SR_K);
    pos_sub  = pos_dbl - SR_K;
    quad_odd = pos_r[AW];
    k_idx    = pos_r[AW-1:0];
    rom_addr = quad_odd ? (~k_idx + AW'(1)) : k_idx;
    sine_mag = (quad_odd && (k_idx == '0)) ? estg_pkg::SINE_PEAK
                                           : tab_r[estg_pkg::SINE_MAG_W-1:0];
    mag      = prod_r[estg_pkg::PROD_SHIFT +: estg_pkg::AMP_W];
    neg      = pos_r[POS_W-1];
  end

  always_ff @(posedge clk) begin
    tab_r <= estg_pkg::SINE_ROM[rom_addr];
    if (ctl.load) begin
      env_rem_r <= env_full ? '0 : env_num;
      acc_r     <= env_full ? ACC_W'(amp) : '0;
      amp_r     <= amp;
      pos_rem_r <= residue;
      pos_r     <= '0;
    end else begin
      if (ctl.step) begin
        env_rem_r <= env_bit ? env_sub[N_W-1:0] : env_dbl[N_W-1:0];
        acc_r     <= acc_nxt;
      end
      if (ctl.pos_step) begin
        pos_rem_r <= pos_bit ? pos_sub[PHASE_W-1:0] : pos_dbl[PHASE_W-1:0];
        pos_r     <= {pos_r[POS_W-2:0], pos_bit};
      end
    end
    if (ctl.mul) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(sine_mag);
    end
  end

endmodule

`default_nettype wire

### design/enveloped_sine_tone_generator.sv
// Top level of the enveloped sine tone generator: control, registers, tone state, result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready   | in_start_req
//  out     | out       | out_valid / out_ready | out_left_sample, out_right_sample,
//          |           |                       | out_tone_active, out_last
//
// An accepted tone sample passes through ST_CALC (the bit-serial envelope and phase loop with the
// table read overlapped), ST_MUL (the multiply) and ST_DONE, which loads the result register.
// A silent tick goes straight to ST_DONE. No new item is taken until the last one is loaded.
// After reset and after every register write the tone length is found by a bit-serial divide
// by 1000 over the rate*duration product in ST_LOAD and ST_SETUP, in_ready low.
// A finished item waits while the result register holds an item not yet taken, in_ready low.
`default_nettype none

`include "enveloped_sine_tone_generator_defines.svh"

module enveloped_sine_tone_generator #(
  parameter int FS_HZ = 16000
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [estg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [estg_pkg::DUR_W-1:0]            cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_start_req,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [estg_pkg::SAMPLE_W-1:0]       out_left_sample,
  output logic signed [estg_pkg::SAMPLE_W-1:0]       out_right_sample,
  output logic                                       out_tone_active,
  output logic                                       out_last
);

  localparam int PHASE_W    = $clog2(FS_HZ);
  localparam int FADE       = FS_HZ / estg_pkg::FADE_DIV;
  localparam int N_W        = $clog2(FADE);
  localparam int IDX_W      = estg_pkg::IDX_W;
  localparam int DIVIDEND_W = $clog2(FS_HZ * ((1 << estg_pkg::DUR_W) - 1) + 1);
  localparam int CNT_W      = $clog2(DIVIDEND_W);
  localparam int MSR_W      = $clog2(estg_pkg::MS_PER_S);
  localparam int SAMPLE_W   = estg_pkg::SAMPLE_W;

  localparam logic [PHASE_W:0]  SR_K   = (PHASE_W + 1)'(FS_HZ);
  localparam logic [MSR_W:0]    MS_K   = (MSR_W + 1)'(estg_pkg::MS_PER_S);
  localparam logic [IDX_W-1:0]  FADE_I = IDX_W'(FADE);

  estg_pkg::estg_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;

  logic [estg_pkg::VOL_W-1:0]   vol_r;
  logic [estg_pkg::FREQ_W-1:0]  freq_r;
  logic [estg_pkg::DUR_W-1:0]   dur_r;
  logic [IDX_W-1:0]             total_r;
  logic [MSR_W-1:0]             tdiv_rem_r;
  logic [DIVIDEND_W-1:0]        tdiv_num_r;

  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [PHASE_W-1:0]           ph_r, ph_nxt;
  logic                         play_r, play_nxt;
  logic                         act_r;
  logic                         fin_r;

  logic                         out_valid_r;
  logic signed [SAMPLE_W-1:0]   out_sample_r;
  logic                         out_act_r;
  logic                         out_last_r;

  logic                         cfg_fire;
  logic                         in_fire;
  logic                         out_load;
  logic                         total_load;
  estg_pkg::estg_dp_ctl_t       dp_ctl;

  logic [estg_pkg::VOL_W-1:0]   vol_sat;
  logic [estg_pkg::AMP_W-1:0]   amp;
  logic [PHASE_W:0]             freq_ext;
  logic [PHASE_W:0]             step_w;
  logic [IDX_W-1:0]             idx_eff;
  logic [PHASE_W-1:0]           ph_eff;
  logic                         play_eff;
  logic                         run;
  logic [IDX_W:0]               idx_inc;
  logic                         fin;
  logic [PHASE_W:0]             ph_sum;
  logic [PHASE_W:0]             ph_wrap;
  logic                         rise;
  logic                         fall;
  logic                         env_full;
  logic [IDX_W-1:0]             tail;
  logic [N_W-1:0]               env_num;

  logic [MSR_W:0]               tdiv_dbl;
  logic [MSR_W:0]               tdiv_sub;
  logic                         tdiv_bit;
  logic [DIVIDEND_W-1:0]        tdiv_shift;
  logic [IDX_W-1:0]             total_sat;

  logic [estg_pkg::AMP_W-1:0]   dp_mag;
  logic                         dp_neg;
  logic [SAMPLE_W-1:0]          mag_ext;
  logic signed [SAMPLE_W-1:0]   sample_val;

  assign cfg_fire = cfg_valid & cfg_ready;
  assign in_fire  = in_valid & in_ready;

  // register-derived values
  always_comb begin
    vol_sat  = (vol_r > estg_pkg::VOL_MAX) ? estg_pkg::VOL_MAX : vol_r;
    amp      = estg_pkg::AMP_W'(vol_sat) * estg_pkg::AMP_PER_PCT;
    freq_ext = (PHASE_W + 1)'(freq_r);
    step_w   = (freq_ext >= SR_K) ? (freq_ext - SR_K) : freq_ext;
  end

  // tone length divider step
  always_comb begin
    tdiv_dbl   = {tdiv_rem_r, tdiv_num_r[DIVIDEND_W-1]};
    tdiv_bit   = (tdiv_dbl >= MS_K);
    tdiv_sub   = tdiv_dbl - MS_K;
    tdiv_shift = {tdiv_num_r[DIVIDEND_W-2:0], tdiv_bit};
    total_sat  = (tdiv_shift > DIVIDEND_W'(estg_pkg::MAX_TOTAL)) ? estg_pkg::MAX_TOTAL
                                                                 : tdiv_shift[IDX_W-1:0];
  end

  // tone state update for the accepted tick
  always_comb begin
    idx_eff  = in_start_req ? '0 : idx_r;
    ph_eff   = in_start_req ? '0 : ph_r;
    play_eff = in_start_req | play_r;
    run      = play_eff && (idx_eff < total_r);
    idx_inc  = (IDX_W + 1)'(idx_eff) + (IDX_W + 1)'(1);
    fin      = (idx_inc >= (IDX_W + 1)'(total_r));
    ph_sum   = (PHASE_W + 1)'(ph_eff) + step_w;
    ph_wrap  = (ph_sum >= SR_K) ? (ph_sum - SR_K) : ph_sum;
    rise     = (idx_eff < FADE_I);
    fall     = ((IDX_W + 1)'(idx_eff) + (IDX_W + 1)'(FADE_I)) > (IDX_W + 1)'(total_r);
    env_full = !rise && !fall;
    tail     = total_r - idx_eff;
    env_num  = rise ? idx_eff[N_W-1:0] : tail[N_W-1:0];

    idx_nxt  = idx_r;
    ph_nxt   = ph_r;
    play_nxt = play_r;
    if (in_fire) begin
      if (run && !fin) begin
        idx_nxt  = idx_inc[IDX_W-1:0];
        ph_nxt   = ph_wrap[PHASE_W-1:0];
        play_nxt = 1'b1;
      end else begin
        idx_nxt  = '0;
        ph_nxt   = '0;
        play_nxt = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      estg_pkg::ST_LOAD: begin
        state_nxt = estg_pkg::ST_SETUP;
      end
      estg_pkg::ST_SETUP: begin
        if (cfg_fire) begin
          state_nxt = estg_pkg::ST_LOAD;
        end else if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
          state_nxt = estg_pkg::ST_IDLE;
        end
      end
      estg_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          state_nxt = estg_pkg::ST_LOAD;
        end else if (in_fire) begin
          state_nxt = run ? estg_pkg::ST_CALC : estg_pkg::ST_DONE;
        end
      end
      estg_pkg::ST_CALC: begin
        if (cnt_r == CNT_W'(estg_pkg::ENV_STEPS - 1)) begin
          state_nxt = estg_pkg::ST_MUL;
        end
      end
      estg_pkg::ST_MUL: begin
        state_nxt = estg_pkg::ST_DONE;
      end
      estg_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = estg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = estg_pkg::ST_LOAD;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready        = 1'b0;
    cfg_ready       = 1'b0;
    out_load        = 1'b0;
    total_load      = 1'b0;
    dp_ctl          = '0;
    cnt_nxt         = '0;
    unique case (state_r)
      estg_pkg::ST_LOAD: begin
        cfg_ready = 1'b0;
      end
      estg_pkg::ST_SETUP: begin
        cfg_ready  = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        total_load = !cfg_valid && (cnt_r == CNT_W'(DIVIDEND_W - 1));
      end
      estg_pkg::ST_IDLE: begin
        cfg_ready   = 1'b1;
        in_ready    = !cfg_valid;
        dp_ctl.load = in_valid && !cfg_valid;
      end
      estg_pkg::ST_CALC: begin
        dp_ctl.step     = 1'b1;
        dp_ctl.pos_step = (cnt_r < CNT_W'(estg_pkg::POS_W));
        cnt_nxt         = cnt_r + CNT_W'(1);
      end
      estg_pkg::ST_MUL: begin
        dp_ctl.mul = 1'b1;
      end
      estg_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        cfg_ready = 1'b0;
      end
    endcase
  end

  assign mag_ext    = SAMPLE_W'(dp_mag);
  assign sample_val = act_r ? (dp_neg ? -$signed(mag_ext) : $signed(mag_ext))
                            : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= estg_pkg::ST_LOAD;
      cnt_r       <= '0;
      vol_r       <= estg_pkg::VOL_RESET;
      freq_r      <= estg_pkg::FREQ_RESET;
      dur_r       <= estg_pkg::DUR_RESET;
      idx_r       <= '0;
      ph_r        <= '0;
      play_r      <= 1'b0;
      act_r       <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      ph_r    <= ph_nxt;
      play_r  <= play_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          estg_pkg::CFG_VOLUME:   vol_r  <= cfg_data[estg_pkg::VOL_W-1:0];
          estg_pkg::CFG_FREQ:     freq_r <= cfg_data[estg_pkg::FREQ_W-1:0];
          estg_pkg::CFG_DURATION: dur_r  <= cfg_data;
          default: begin
            vol_r <= vol_r;
          end
        endcase
      end
      if (in_fire) begin
        act_r <= run;
        fin_r <= run && fin;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == estg_pkg::ST_LOAD) begin
      tdiv_rem_r <= '0;
      tdiv_num_r <= DIVIDEND_W'(FS_HZ) * DIVIDEND_W'(dur_r);
    end else if (state_r == estg_pkg::ST_SETUP) begin
      tdiv_rem_r <= tdiv_bit ? tdiv_sub[MSR_W-1:0] : tdiv_dbl[MSR_W-1:0];
      tdiv_num_r <= tdiv_shift;
    end
    if (total_load) begin
      total_r <= total_sat;
    end
    if (out_load) begin
      out_sample_r <= sample_val;
      out_act_r    <= act_r;
      out_last_r   <= fin_r;
    end
  end

  estg_sample_dp #(
    .FS_HZ (FS_HZ)
  ) u_dp (
    .clk      (clk),
    .ctl      (dp_ctl),
    .env_num  (env_num),
    .env_full (env_full),
    .amp      (amp),
    .residue  (ph_eff),
    .mag      (dp_mag),
    .neg      (dp_neg)
  );

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_sample_r;
  assign out_right_sample = out_sample_r;
  assign out_tone_active  = out_act_r;
  assign out_last         = out_last_r;

  `ESTG_ASSERT_SAME(a_idle_state_clear, !play_r, (idx_r == '0) && (ph_r == '0), "idle tone state not cleared")
  `ESTG_ASSERT_SAME(a_phase_in_range, 1'b1, (PHASE_W + 1)'(ph_r) < SR_K, "phase residue out of range")
  `ESTG_ASSERT_NEXT(a_start_plays, in_fire && in_start_req && (total_r > IDX_W'(1)), play_r, "start did not begin tone")
  `ESTG_ASSERT_SAME(a_last_is_active, out_load && fin_r, act_r, "final sample marked silent")

endmodule

`default_nettype wire

### sim/enveloped_sine_tone_generator_tb.sv
// Testbench for the enveloped sine tone generator: directed table, random tones, sample predictor.
`timescale 1ns / 100ps

module enveloped_sine_tone_generator_tb;

  localparam int TONE_RATE    = 16000;
  localparam int FADE_LEN     = TONE_RATE / 50;
  localparam int LONGEST_TONE = 262143;
  localparam int RANDOM_ITEMS = 1400;
  localparam int SAMPLE_W     = estg_pkg::SAMPLE_W;
  localparam int DUR_W        = estg_pkg::DUR_W;
  localparam int SINE_DEPTH   = estg_pkg::SINE_DEPTH;

  localparam estg_pkg::estg_cfg_idx_t CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       act;
    logic                       lst;
  } tone_sample_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_TICK,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    estg_pkg::estg_cfg_idx_t  reg_idx;
    logic [DUR_W-1:0]         data;
    logic                     start;
    logic [4:0]               reps;
    tone_sample_t             want;
  } directed_row_t;

  localparam int N_ROWS = 20;
  localparam directed_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{ROW_CHECKED, estg_pkg::CFG_VOLUME,   14'd0,    1'b0, 5'd1,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, estg_pkg::CFG_VOLUME,   14'd0,    1'b1, 5'd1,  '{14'sd0, 1'b1, 1'b0}},
    '{ROW_TICK,    estg_pkg::CFG_VOLUME,   14'd0,    1'b0, 5'd1,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_WRITE,   estg_pkg::CFG_VOLUME,   14'd0,    1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, estg_pkg::CFG_VOLUME,   14'd0,    1'b0, 5'd1,  '{14'sd0, 1'b1, 1'b0}},
    '{ROW_WRITE,   estg_pkg::CFG_VOLUME,   14'h3fff, 1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_WRITE,   estg_pkg::CFG_FREQ,     14'h1fff, 1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_WRITE,   estg_pkg::CFG_DURATION, 14'h3fff, 1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_TICK,    estg_pkg::CFG_VOLUME,   14'd0,    1'b0, 5'd1,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, estg_pkg::CFG_VOLUME,   14'd0,    1'b1, 5'd1,  '{14'sd0, 1'b1, 1'b0}},
    '{ROW_WRITE,   estg_pkg::CFG_DURATION, 14'd0,    1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, estg_pkg::CFG_VOLUME,   14'd0,    1'b0, 5'd1,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, estg_pkg::CFG_VOLUME,   14'd0,    1'b1, 5'd1,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_WRITE,   CFG_SPARE,              14'h2aaa, 1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_WRITE,   estg_pkg::CFG_DURATION, 14'd1,    1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_WRITE,   estg_pkg::CFG_VOLUME,   14'd100,  1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_WRITE,   estg_pkg::CFG_FREQ,     14'd4000, 1'b0, 5'd0,  '{14'sd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, estg_pkg::CFG_VOLUME,   14'd0,    1'b1, 5'd1,  '{14'sd0, 1'b1, 1'b0}},
    '{ROW_TICK,    estg_pkg::CFG_VOLUME,   14'd0,    1'b0, 5'd15, '{14'sd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, estg_pkg::CFG_VOLUME,   14'd0,    1'b0, 5'd1,  '{14'sd0, 1'b0, 1'b0}}
  };

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  estg_pkg::estg_cfg_idx_t    cfg_index    = estg_pkg::CFG_VOLUME;
  logic [DUR_W-1:0]           cfg_data     = '0;
  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic                       in_start_req = 1'b0;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left_sample;
  logic signed [SAMPLE_W-1:0] out_right_sample;
  logic                       out_tone_active;
  logic                       out_last;

  logic [15:0]                 sine_q15 [SINE_DEPTH];
  logic [estg_pkg::VOL_W-1:0]  tone_vol  = 7'd80;
  logic [estg_pkg::FREQ_W-1:0] tone_freq = 13'd1000;
  logic [DUR_W-1:0]            tone_dur  = 14'd100;
  int unsigned                 tone_idx   = 0;
  int unsigned                 tone_phase = 0;
  bit                          tone_on    = 1'b0;

  tone_sample_t expected_samples [$];
  int           mismatch_count = 0;
  int           send_idle_pct  = 38;
  int           recv_idle_pct  = 76;
  int           items_sent     = 0;

  enveloped_sine_tone_generator #(
    .FS_HZ(TONE_RATE)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_req    (in_start_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_sample (out_left_sample),
    .out_right_sample(out_right_sample),
    .out_tone_active (out_tone_active),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] quarter_sine_q15(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] v;
    int          divisors [5];
    divisors = '{110, 72, 42, 20, 6};
    x  = (64'(k) * 64'd1686629713) / SINE_DEPTH;
    x2 = (x * x) >> 30;
    h  = 64'd1 << 30;
    foreach (divisors[j]) begin
      h = (64'd1 << 30) - ((x2 * h) >> 30) / divisors[j];
    end
    s = (x * h) >> 30;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? 16'd32767 : v[15:0];
  endfunction

  function automatic tone_sample_t next_tone_sample(input logic st);
    logic [63:0]  total;
    logic [63:0]  env;
    logic [63:0]  mag;
    logic [63:0]  pos;
    int unsigned  vol;
    int unsigned  amp;
    int unsigned  quad;
    int unsigned  k;
    int unsigned  m;
    tone_sample_t r;
    total = (64'(TONE_RATE) * tone_dur) / 1000;
    if (total > LONGEST_TONE) begin
      total = LONGEST_TONE;
    end
    vol = (tone_vol > 100) ? 100 : tone_vol;
    amp = 8000 * vol / 100;
    r   = '0;
    if (st) begin
      tone_on    = 1'b1;
      tone_idx   = 0;
      tone_phase = 0;
    end
    if (tone_on && tone_idx >= total) begin
      tone_on    = 1'b0;
      tone_idx   = 0;
      tone_phase = 0;
    end
    if (tone_on) begin
      if (tone_idx < FADE_LEN) begin
        env = (64'(tone_idx) << 16) / FADE_LEN;
      end else if (longint'(tone_idx) > longint'(total) - FADE_LEN) begin
        env = ((total - tone_idx) << 16) / FADE_LEN;
      end else begin
        env = 64'd65536;
      end
      pos  = (64'(tone_phase) * 4 * SINE_DEPTH) / TONE_RATE;
      quad = (pos / SINE_DEPTH) % 4;
      k    = pos % SINE_DEPTH;
      if (quad == 0 || quad == 2) begin
        m = sine_q15[k];
      end else if (k == 0) begin
        m = 32767;
      end else begin
        m = sine_q15[SINE_DEPTH - k];
      end
      mag   = (64'(amp) * env * m) >> 31;
      r.smp = (quad >= 2) ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
      r.act = 1'b1;
      tone_idx   = tone_idx + 1;
      tone_phase = (tone_phase + tone_freq % TONE_RATE) % TONE_RATE;
      if (tone_idx >= total) begin
        r.lst      = 1'b1;
        tone_on    = 1'b0;
        tone_idx   = 0;
        tone_phase = 0;
      end
    end
    return r;
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return '0;
    end else if (r < 60) begin
      return DUR_W'($urandom_range(1, 20));
    end else if (r < 85) begin
      return DUR_W'($urandom_range(21, 40));
    end else if (r < 95) begin
      return DUR_W'($urandom_range(41, 45));
    end
    return DUR_W'($urandom_range(46, 16383));
  endfunction

  task automatic write_register(input estg_pkg::estg_cfg_idx_t idx,
                                input logic [DUR_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      estg_pkg::CFG_VOLUME:   tone_vol  = data[estg_pkg::VOL_W-1:0];
      estg_pkg::CFG_FREQ:     tone_freq = data[estg_pkg::FREQ_W-1:0];
      estg_pkg::CFG_DURATION: tone_dur  = data;
      default: ;
    endcase
  endtask

  task automatic send_tick(input logic st, input bit typed, input tone_sample_t typed_want);
    tone_sample_t predicted;
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= st;
    do @(posedge clk); while (!in_ready);
    predicted = next_tone_sample(st);
    expected_samples.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  task automatic check_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    tone_sample_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected item, expected none actual left %0d right %0d active %0b last %0b",
                 $time, out_left_sample, out_right_sample, out_tone_active, out_last);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        check_field("left_sample", want.smp, out_left_sample);
        check_field("right_sample", want.smp, out_right_sample);
        check_field("tone_active", want.act, out_tone_active);
        check_field("last", want.lst, out_last);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int            n;
    int            tone_len;
    int            drain_cycles;
    int unsigned   pick;
    bit            opens_tone;
    logic          st;
    directed_row_t row;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      sine_q15[k] = quarter_sine_q15(k);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        write_register(row.reg_idx, row.data);
      end else begin
        repeat (row.reps) send_tick(row.start, row.kind == ROW_CHECKED, row.want);
      end
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 76;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          write_register(CFG_SPARE, DUR_W'($urandom_range(0, 16383)));
        end else if (pick < 7) begin
          write_register(estg_pkg::CFG_VOLUME, DUR_W'($urandom_range(0, 16383)));
        end else if (pick < 13) begin
          write_register(estg_pkg::CFG_FREQ, DUR_W'($urandom_range(0, 16383)));
        end else begin
          write_register(estg_pkg::CFG_DURATION, pick_duration());
        end
      end
      tone_len   = (TONE_RATE * int'(tone_dur)) / 1000;
      opens_tone = ($urandom_range(0, 9) < 8);
      if (tone_len == 0 || tone_len > 1000) begin
        n = $urandom_range(1, 40);
      end else if ($urandom_range(0, 9) < 8) begin
        n = tone_len + $urandom_range(0, 2);
      end else begin
        n = $urandom_range(1, tone_len);
      end
      if (n > RANDOM_ITEMS - items_sent) begin
        n = RANDOM_ITEMS - items_sent;
      end
      for (int k = 0; k < n; k++) begin
        st = (k == 0 && opens_tone) || ($urandom_range(0, 99) < 2);
        send_tick(st, 1'b0, '0);
      end
    end

    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_samples.size() != 0 && drain_cycles < 100000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (expected_samples.size() != 0) begin
        $display("%0t: %0d expected items never arrived", $time, expected_samples.size());
      end
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
